// ===== hdl/dst_pkg.sv =====
// dst_pkg: shared types and codes for the dedup set table.
// Holds the request/response item structs, request and status codes, and FSM states.
// No dependencies.
`default_nettype none

package dst_pkg;

  // Default sizing handed to the top level parameters
  localparam int DEPTH_DEF    = 16;
  localparam int KEY_BITS_DEF = 32;

  // Fixed field widths of the item interface
  localparam int REQ_TYPE_W = 3;
  localparam int KEY_W      = 32;
  localparam int INDEX_W    = 4;
  localparam int STATUS_W   = 3;
  localparam int VALUE_W    = 32;
  localparam int COUNT_W    = 5;

  // Request codes
  localparam logic [REQ_TYPE_W-1:0] REQ_INSERT = 3'd0;
  localparam logic [REQ_TYPE_W-1:0] REQ_QUERY  = 3'd1;
  localparam logic [REQ_TYPE_W-1:0] REQ_POP    = 3'd2;
  localparam logic [REQ_TYPE_W-1:0] REQ_CLEAR  = 3'd3;
  localparam logic [REQ_TYPE_W-1:0] REQ_READ   = 3'd4;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 3'd0;
  localparam logic [STATUS_W-1:0] ST_DUP   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 3'd3;
  localparam logic [STATUS_W-1:0] ST_RANGE = 3'd4;

  typedef struct packed {
    logic [REQ_TYPE_W-1:0] req_type;
    logic [KEY_W-1:0]      key;
    logic [INDEX_W-1:0]    index;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                found;
    logic [VALUE_W-1:0]  read_value;
    logic [COUNT_W-1:0]  count;
  } rsp_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_READ,
    S_FIN
  } state_t;

endpackage

`default_nettype wire

// ===== hdl/dst_key_ram.sv =====
// dst_key_ram: key storage for the dedup set table.
// One write port, one read port with registered read data. No dependencies.
`default_nettype none

module dst_key_ram #(
  parameter int DEPTH     = 16,
  parameter int WIDTH     = 32,
  parameter int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                 clk,
  input  wire logic                 we,
  input  wire logic [ADDR_BITS-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]     wr_data,
  input  wire logic [ADDR_BITS-1:0] rd_addr,
  output logic      [WIDTH-1:0]     rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

// ===== hdl/dedup_set_table_unit.sv =====
// dedup_set_table_unit: top level of the dedup set table.
// Depends on dst_pkg and dst_key_ram.
//
// A bounded set of up to DEPTH keys kept in insertion order, stored in a single-port-read
// RAM and searched one entry per cycle. One item is in work at a time: req_ready is high
// only while the sequencer is idle. Insert and query read the stored entries one per
// cycle through the RAM read port and compare each against the key, stopping early on a
// match, and then pass to the finishing step. Read by index makes one RAM read before
// the finishing step; pop, clear and unused codes go straight to it. In every case
// req_ready returns in the cycle the result appears. The result sits in an output
// register, so a new item is accepted while the previous result still waits; the
// finishing step stalls only if that register is still full. There is no clearing pass
// after reset: only entries below the count ever reach a compare or a result.
`default_nettype none

module dedup_set_table_unit
  import dst_pkg::*;
#(
  parameter int DEPTH    = DEPTH_DEF,
  parameter int KEY_BITS = KEY_BITS_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic req_valid,
  output logic      req_ready,
  input  wire req_t req,
  output logic      rsp_valid,
  input  wire logic rsp_ready,
  output rsp_t      rsp
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int IW = (CW > INDEX_W) ? CW : INDEX_W;

  // Sequencer and control registers
  state_t              state, state_next;
  logic [CW-1:0]       cnt, cnt_next;
  logic [CW-1:0]       ptr, ptr_next;
  logic                hit, hit_next;
  logic                cmp_vld, cmp_vld_next;
  logic                rsp_valid_q;
  logic                rsp_valid_next;

  // Latched request payload
  logic [REQ_TYPE_W-1:0] op, op_next;
  logic [KEY_BITS-1:0]   key_q, key_next;
  logic [INDEX_W-1:0]    idx_q, idx_next;
  rsp_t                  rsp_q, rsp_next;

  // RAM interface
  logic                mem_we;
  logic [AW-1:0]       rd_addr;
  logic [KEY_BITS-1:0] rd_data;

  // Datapath helpers
  logic          match;
  logic          issue;
  logic [IW-1:0] idx_ext;
  logic [IW-1:0] cnt_ext;
  logic          in_range;

  dst_key_ram #(
    .DEPTH     (DEPTH),
    .WIDTH     (KEY_BITS),
    .ADDR_BITS (AW)
  ) u_ram (
    .clk     (clk),
    .we      (mem_we),
    .wr_addr (cnt[AW-1:0]),
    .wr_data (key_q),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign idx_ext  = IW'(idx_q);
  assign cnt_ext  = IW'(cnt);
  assign in_range = idx_ext < cnt_ext;

  // Shared compare: RAM data from the read issued last cycle against the key
  assign match = cmp_vld && (rd_data == key_q);
  assign issue = (ptr < cnt) && !hit && !match;

  assign rsp_valid = rsp_valid_q;
  assign rsp       = rsp_q;

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      cnt         <= '0;
      ptr         <= '0;
      hit         <= 1'b0;
      cmp_vld     <= 1'b0;
      rsp_valid_q <= 1'b0;
    end else begin
      state       <= state_next;
      cnt         <= cnt_next;
      ptr         <= ptr_next;
      hit         <= hit_next;
      cmp_vld     <= cmp_vld_next;
      rsp_valid_q <= rsp_valid_next;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    op    <= op_next;
    key_q <= key_next;
    idx_q <= idx_next;
    rsp_q <= rsp_next;
  end

  // Sequencer: next state, RAM control and result formation
  always_comb begin
    state_next     = state;
    cnt_next       = cnt;
    ptr_next       = ptr;
    hit_next       = hit;
    cmp_vld_next   = 1'b0;
    rsp_valid_next = rsp_valid_q && !rsp_ready;
    rsp_next       = rsp_q;
    op_next        = op;
    key_next       = key_q;
    idx_next       = idx_q;
    mem_we         = 1'b0;
    req_ready      = 1'b0;
    rd_addr        = (op == REQ_READ) ? idx_ext[AW-1:0] : ptr[AW-1:0];

    case (state)
      S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          op_next  = req.req_type;
          key_next = KEY_BITS'(req.key);
          idx_next = req.index;
          ptr_next = '0;
          hit_next = 1'b0;
          if (req.req_type == REQ_INSERT || req.req_type == REQ_QUERY) begin
            state_next = S_SCAN;
          end else if (req.req_type == REQ_READ) begin
            state_next = S_READ;
          end else begin
            state_next = S_FIN;
          end
        end
      end

      // One RAM read issued and one compare retired per cycle
      S_SCAN: begin
        hit_next = hit || match;
        if (issue) begin
          cmp_vld_next = 1'b1;
          ptr_next     = ptr + CW'(1);
        end else begin
          state_next = S_FIN;
        end
      end

      // Read data for the indexed entry lands next cycle
      S_READ: begin
        state_next = S_FIN;
      end

      // Commit the update and load the result register once it is free
      S_FIN: begin
        if (!rsp_valid_q || rsp_ready) begin
          rsp_next.status     = ST_OK;
          rsp_next.found      = 1'b0;
          rsp_next.read_value = '0;
          case (op)
            REQ_INSERT: begin
              if (hit) begin
                rsp_next.status = ST_DUP;
              end else if (cnt == CW'(DEPTH)) begin
                rsp_next.status = ST_FULL;
              end else begin
                mem_we   = 1'b1;
                cnt_next = cnt + CW'(1);
              end
            end
            REQ_QUERY: begin
              rsp_next.found = hit;
            end
            REQ_POP: begin
              if (cnt == '0) begin
                rsp_next.status = ST_EMPTY;
              end else begin
                cnt_next = cnt - CW'(1);
              end
            end
            REQ_CLEAR: begin
              cnt_next = '0;
            end
            REQ_READ: begin
              if (in_range) begin
                rsp_next.read_value = VALUE_W'(rd_data);
              end else begin
                rsp_next.status = ST_RANGE;
              end
            end
            default: begin
            end
          endcase
          rsp_next.count = COUNT_W'(cnt_next);
          rsp_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== verif/testbench.sv =====
// Testbench for dedup_set_table_unit: directed and random request streams with random idling.
// A scoreboard class tracks its own copy of the key set and checks each response item.
// Depends on dst_pkg and the dedup_set_table_unit RTL.
`timescale 1ns / 100ps

module testbench;
  import dst_pkg::*;

  localparam int SET_DEPTH   = DEPTH_DEF;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_WAIT  = 40;
  localparam int RANDOM_REQS = 600;
  localparam int POOL_SIZE   = 24;
  localparam int HOLD_CYCLES = 300;

  // request codes the block treats as no-ops
  localparam logic [REQ_TYPE_W-1:0] REQ_SPARE_FIRST = 3'd5;
  localparam logic [REQ_TYPE_W-1:0] REQ_SPARE_LAST  = 3'd7;

  localparam logic [KEY_W-1:0] KEY_MASK = (KEY_BITS_DEF >= KEY_W) ? {KEY_W{1'b1}} :
                                          KEY_W'((64'd1 << KEY_BITS_DEF) - 1);

  // Tracks the stored keys and the response items still owed by the block
  class key_set_tracker;
    logic [KEY_W-1:0] stored_keys [SET_DEPTH];
    int unsigned      key_count;
    rsp_t             owed_rsps [$];
    int unsigned      mismatches;
    int unsigned      rsps_seen;

    function new();
      key_count  = 0;
      mismatches = 0;
      rsps_seen  = 0;
    endfunction

    function bit holds(logic [KEY_W-1:0] k);
      for (int i = 0; i < key_count; i++) begin
        if (stored_keys[i] == k) return 1'b1;
      end
      return 1'b0;
    endfunction

    // Apply one accepted request and queue the response it must produce
    function void apply_request(req_t r);
      rsp_t             want;
      logic [KEY_W-1:0] k;
      k    = r.key & KEY_MASK;
      want = '0;
      want.status = ST_OK;
      case (r.req_type)
        REQ_INSERT: begin
          if (holds(k)) want.status = ST_DUP;
          else if (key_count >= SET_DEPTH) want.status = ST_FULL;
          else begin
            stored_keys[key_count] = k;
            key_count++;
          end
        end
        REQ_QUERY: want.found = holds(k);
        REQ_POP: begin
          if (key_count == 0) want.status = ST_EMPTY;
          else key_count--;
        end
        REQ_CLEAR: key_count = 0;
        REQ_READ: begin
          if (r.index >= key_count) want.status = ST_RANGE;
          else want.read_value = stored_keys[r.index];
        end
        default: ;
      endcase
      want.count = key_count[COUNT_W-1:0];
      owed_rsps = {owed_rsps, want};
    endfunction

    // Compare one response item against the oldest owed one
    function void check_response(rsp_t got);
      rsp_t want;
      rsps_seen++;
      if (owed_rsps.size() == 0) begin
        $error("response with none owed: status %0d count %0d", got.status, got.count);
        mismatches++;
        return;
      end
      want = owed_rsps.pop_front();
      if (got.status !== want.status) begin
        $error("status: expected %0d, actual %0d", want.status, got.status);
        mismatches++;
      end
      if (got.found !== want.found) begin
        $error("found: expected %0d, actual %0d", want.found, got.found);
        mismatches++;
      end
      if (got.read_value !== want.read_value) begin
        $error("read_value: expected %h, actual %h", want.read_value, got.read_value);
        mismatches++;
      end
      if (got.count !== want.count) begin
        $error("count: expected %0d, actual %0d", want.count, got.count);
        mismatches++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic req_valid;
  logic req_ready;
  req_t req;
  logic rsp_valid;
  logic rsp_ready;
  rsp_t rsp;

  key_set_tracker   tracker = new();
  int unsigned      reqs_sent;
  int unsigned      cycle_count;
  logic [KEY_W-1:0] key_pool [POOL_SIZE];

  dedup_set_table_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  // 10 ns clock
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Run limit
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("dedup_set_table_unit: mismatch");
      $finish;
    end
  end

  // Response checking at the rising edge
  always @(posedge clk) begin
    if (!rst && rsp_valid && rsp_ready) tracker.check_response(rsp);
  end

  // Response side: random stalls, one long hold-off, and a window with no stalls
  initial begin
    bit held;
    held      = 1'b0;
    rsp_ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (!held && tracker.rsps_seen >= 150) begin
        held = 1'b1;
        rsp_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else begin
        rsp_ready <= (tracker.rsps_seen >= 320 && tracker.rsps_seen < 430) ||
                     ($urandom_range(0, 99) >= 35);
        @(negedge clk);
      end
    end
  end

  // Offer one request item, starting and ending at a falling edge
  task automatic send_req(input logic [REQ_TYPE_W-1:0] op, input logic [KEY_W-1:0] k,
                          input logic [INDEX_W-1:0] idx);
    req_t item;
    item.req_type = op;
    item.key      = k;
    item.index    = idx;
    while (!(reqs_sent >= 350 && reqs_sent < 470) && $urandom_range(0, 99) < 35) begin
      req_valid <= 1'b0;
      @(negedge clk);
    end
    req_valid <= 1'b1;
    req       <= item;
    do @(posedge clk); while (!req_ready);
    tracker.apply_request(item);
    reqs_sent++;
    @(negedge clk);
  endtask

  function automatic logic [KEY_W-1:0] pick_key();
    if ($urandom_range(0, 99) < 70) return key_pool[$urandom_range(0, POOL_SIZE - 1)];
    return $urandom;
  endfunction

  function automatic logic [INDEX_W-1:0] any_index();
    return INDEX_W'($urandom_range(0, 15));
  endfunction

  // Stimulus
  initial begin
    int unsigned useful;
    int unsigned burst;
    int unsigned pick;
    logic [KEY_W-1:0] last_key;

    reqs_sent = 0;
    useful    = 0;
    rst       = 1'b1;
    req_valid = 1'b0;
    req       = '0;
    for (int i = 0; i < POOL_SIZE; i++) key_pool[i] = $urandom;
    key_pool[0] = '0;
    key_pool[1] = '1;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: empty-set cases, extremes, duplicates, range checks, no-op codes
    send_req(REQ_QUERY, '0, '0);
    send_req(REQ_POP, '1, '1);
    send_req(REQ_READ, '0, '0);
    send_req(REQ_INSERT, '0, '0);
    send_req(REQ_INSERT, '1, '1);
    send_req(REQ_INSERT, '0, '1);
    send_req(REQ_QUERY, '1, '0);
    send_req(REQ_QUERY, 32'h1234_5678, '0);
    send_req(REQ_READ, '0, 4'd1);
    send_req(REQ_READ, '1, 4'd2);
    send_req(REQ_READ, '0, '1);
    send_req(REQ_SPARE_FIRST, 32'hdead_beef, 4'd3);
    send_req(REQ_SPARE_FIRST + 3'd1, '1, '1);
    send_req(REQ_SPARE_LAST, '0, '0);
    send_req(REQ_INSERT, 32'ha5a5_5a5a, 4'd9);
    send_req(REQ_POP, '0, '0);
    send_req(REQ_QUERY, 32'ha5a5_5a5a, '0);
    send_req(REQ_CLEAR, 32'h5a5a_a5a5, 4'd6);
    send_req(REQ_READ, '0, '0);
    send_req(REQ_QUERY, '0, '0);

    // Fill to capacity, then refuse a new key and a duplicate
    last_key = '0;
    for (int i = 0; i < SET_DEPTH; i++) begin
      last_key = $urandom;
      send_req(REQ_INSERT, last_key, any_index());
    end
    send_req(REQ_INSERT, 32'hffff_0000, '0);
    send_req(REQ_INSERT, last_key, '0);
    send_req(REQ_READ, '0, '1);
    send_req(REQ_QUERY, last_key, '0);
    send_req(REQ_POP, '0, '0);
    useful = SET_DEPTH + 5;

    // Random sequences drawn mostly from a small key pool so hits and duplicates occur
    while (useful < RANDOM_REQS) begin
      if ($urandom_range(0, 9) == 0) key_pool[$urandom_range(0, POOL_SIZE - 1)] = $urandom;
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        burst = $urandom_range(1, 20);
        repeat (burst) send_req(REQ_INSERT, pick_key(), any_index());
        useful += burst;
      end else if (pick < 65) begin
        burst = $urandom_range(1, 8);
        repeat (burst) send_req(REQ_QUERY, pick_key(), any_index());
        useful += burst;
      end else if (pick < 80) begin
        burst = $urandom_range(1, 6);
        repeat (burst) send_req(REQ_READ, $urandom, any_index());
        useful += burst;
      end else if (pick < 90) begin
        burst = $urandom_range(1, 18);
        repeat (burst) send_req(REQ_POP, $urandom, any_index());
        useful += burst;
      end else if (pick < 95) begin
        send_req(REQ_CLEAR, $urandom, any_index());
        useful++;
      end else begin
        send_req(REQ_TYPE_W'($urandom_range(REQ_SPARE_FIRST, REQ_SPARE_LAST)), $urandom,
                 any_index());
      end
    end
    req_valid <= 1'b0;

    // Drain and settle
    while (tracker.owed_rsps.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (tracker.mismatches == 0) begin
      $display("dedup_set_table_unit: match");
    end else begin
      $display("dedup_set_table_unit: mismatch");
    end
    $finish;
  end

endmodule
